@@ design/edge_conv3x3_stream_top_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the 3x3 edge filter
// Implication checks, with an empty body when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef EDGE_CONV3X3_STREAM_TOP_MACROS_SVH
`define EDGE_CONV3X3_STREAM_TOP_MACROS_SVH

`ifndef SYNTHESIS
// Same-cycle implication, disabled during reset.
`define EDGE3_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
// Next-cycle implication, disabled during reset.
`define EDGE3_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);
`else
`define EDGE3_ASSERT_IMP(lbl, clk, rst, ante, cons, msg)
`define EDGE3_ASSERT_NXT(lbl, clk, rst, ante, cons, msg)
`endif

`endif

@@ design/edge3_pkg.sv @@
// ----------------------------------------------------------------------------
// edge3_pkg
// Shared types, widths and helpers of the 3x3 vertical-edge filter.
// ----------------------------------------------------------------------------
`default_nettype none

package edge3_pkg;

   localparam int PIX_W      = 8;
   localparam int DIM_W      = 10;
   localparam int CNT_W      = 19;
   localparam int SUM_W      = 11;
   localparam int CSUM_W     = 10;
   localparam int CSR_IDX_W  = 4;
   localparam int RSP_DATA_W = 16;
   localparam int MAX_HEIGHT = 512;
   localparam int EDGE_MAX   = 765;

   localparam logic [CSR_IDX_W-1:0] REG_IMAGE_WIDTH  = 4'd0;
   localparam logic [CSR_IDX_W-1:0] REG_IMAGE_HEIGHT = 4'd1;

   typedef struct packed {
      logic [DIM_W-1:0] w;
      logic [CNT_W-1:0] frame;
      logic [CNT_W-1:0] fmw;   // frame size minus one row
   } cfg_type;

   typedef struct packed {
      logic [PIX_W-1:0] px;
      logic [DIM_W-1:0] col;
      logic             has_result;
      logic             top_ok;
      logic             bot_ok;
      logic             left_ok;
      logic             right_ok;
      logic             last;
   } item_type;

   typedef struct packed {
      logic [PIX_W-1:0] upper;
      logic [PIX_W-1:0] lower;
   } line_word_type;

   localparam int LINE_W = $bits(line_word_type);

   typedef struct packed {
      logic [PIX_W-1:0] top;
      logic [PIX_W-1:0] mid;
      logic [PIX_W-1:0] bot;
   } col_type;

   function automatic logic [DIM_W-1:0] clamp_height(logic [DIM_W-1:0] v);
      logic [DIM_W-1:0] r;
      if (v == '0) begin
         r = DIM_W'(1);
      end else if (v > DIM_W'(MAX_HEIGHT)) begin
         r = DIM_W'(MAX_HEIGHT);
      end else begin
         r = v;
      end
      return r;
   endfunction

   // Column sum with the rows outside the image masked to zero.
   function automatic logic [CSUM_W-1:0] col_sum(col_type c, logic top_ok, logic bot_ok);
      logic [CSUM_W-1:0] s;
      s = CSUM_W'(c.mid);
      if (top_ok) s = s + CSUM_W'(c.top);
      if (bot_ok) s = s + CSUM_W'(c.bot);
      return s;
   endfunction

endpackage

`default_nettype wire

@@ design/edge3_cfg.sv @@
// ----------------------------------------------------------------------------
// edge3_cfg
// Image size registers, clamped on write, with the derived frame sizes.
// ----------------------------------------------------------------------------
`default_nettype none

module edge3_cfg #(
   parameter int MAX_WIDTH = 512
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [edge3_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [edge3_pkg::DIM_W-1:0]         csr_wdata,
   output logic                                restart,
   output edge3_pkg::cfg_type                  cfg
);

   localparam int RESET_W = (MAX_WIDTH < 512) ? MAX_WIDTH : 512;

   logic [edge3_pkg::DIM_W-1:0]   w_ff, w_in, h_ff, h_in, w_clamp;
   logic [edge3_pkg::CNT_W-1:0]   frame_ff, frame_in, fmw_ff, fmw_in;
   logic [2*edge3_pkg::DIM_W-1:0] prod_frame, prod_fmw;
   logic                          wr, is_w, is_h;

   assign csr_ready = 1'b1;
   assign wr        = csr_valid & csr_ready;
   assign is_w      = (csr_index == edge3_pkg::REG_IMAGE_WIDTH);
   assign is_h      = (csr_index == edge3_pkg::REG_IMAGE_HEIGHT);
   assign restart   = wr & (is_w | is_h);

   always_comb begin
      if (csr_wdata == '0) begin
         w_clamp = edge3_pkg::DIM_W'(1);
      end else if (csr_wdata > MAX_WIDTH) begin
         w_clamp = edge3_pkg::DIM_W'(MAX_WIDTH);
      end else begin
         w_clamp = csr_wdata;
      end
      w_in       = (wr & is_w) ? w_clamp : w_ff;
      h_in       = (wr & is_h) ? edge3_pkg::clamp_height(csr_wdata) : h_ff;
      prod_frame = {{edge3_pkg::DIM_W{1'b0}}, w_in} * {{edge3_pkg::DIM_W{1'b0}}, h_in};
      prod_fmw   = {{edge3_pkg::DIM_W{1'b0}}, w_in}
                   * {{edge3_pkg::DIM_W{1'b0}}, h_in - edge3_pkg::DIM_W'(1)};
      frame_in   = prod_frame[edge3_pkg::CNT_W-1:0];
      fmw_in     = prod_fmw[edge3_pkg::CNT_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         w_ff     <= edge3_pkg::DIM_W'(RESET_W);
         h_ff     <= edge3_pkg::DIM_W'(edge3_pkg::MAX_HEIGHT);
         frame_ff <= edge3_pkg::CNT_W'(RESET_W * edge3_pkg::MAX_HEIGHT);
         fmw_ff   <= edge3_pkg::CNT_W'(RESET_W * (edge3_pkg::MAX_HEIGHT - 1));
      end else if (restart) begin
         w_ff     <= w_in;
         h_ff     <= h_in;
         frame_ff <= frame_in;
         fmw_ff   <= fmw_in;
      end
   end

   assign cfg.w     = w_ff;
   assign cfg.frame = frame_ff;
   assign cfg.fmw   = fmw_ff;

endmodule

`default_nettype wire

@@ design/edge3_ctrl.sv @@
// ----------------------------------------------------------------------------
// edge3_ctrl
// Raster position counters; classify each transfer and tag its result.
// ----------------------------------------------------------------------------
`default_nettype none

module edge3_ctrl (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            accept,
   input  logic                            restart,
   input  edge3_pkg::cfg_type              cfg,
   input  logic [edge3_pkg::PIX_W-1:0]     pixel,
   input  logic                            flush,
   output logic                            go,
   output edge3_pkg::item_type             item
);

   logic [edge3_pkg::CNT_W-1:0] pos_ff, pos_in, k_ff, k_in, pos_inc, k_inc;
   logic [edge3_pkg::DIM_W-1:0] col_ff, col_in, ocol_ff, ocol_in, col_inc, ocol_inc;
   logic                        in_frame;

   always_comb begin
      in_frame = (pos_ff < cfg.frame);
      go       = accept & ~(in_frame & flush);
      pos_inc  = pos_ff + edge3_pkg::CNT_W'(1);
      k_inc    = k_ff + edge3_pkg::CNT_W'(1);
      col_inc  = col_ff + edge3_pkg::DIM_W'(1);
      ocol_inc = ocol_ff + edge3_pkg::DIM_W'(1);

      // Drain items carry a zero pixel.
      item.px         = in_frame ? pixel : '0;
      item.col        = col_ff;
      item.has_result = (pos_ff > edge3_pkg::CNT_W'(cfg.w));
      item.top_ok     = (k_ff >= edge3_pkg::CNT_W'(cfg.w));
      item.bot_ok     = (k_ff < cfg.fmw);
      item.left_ok    = (ocol_ff != '0);
      item.right_ok   = (ocol_inc != cfg.w);
      item.last       = (k_inc == cfg.frame);

      pos_in  = pos_ff;
      col_in  = col_ff;
      k_in    = k_ff;
      ocol_in = ocol_ff;
      priority if (restart || (go && item.has_result && item.last)) begin
         pos_in  = '0;
         col_in  = '0;
         k_in    = '0;
         ocol_in = '0;
      end else if (go) begin
         pos_in = pos_inc;
         col_in = (col_inc == cfg.w) ? '0 : col_inc;
         if (item.has_result) begin
            k_in    = k_inc;
            ocol_in = (ocol_inc == cfg.w) ? '0 : ocol_inc;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff  <= '0;
         col_ff  <= '0;
         k_ff    <= '0;
         ocol_ff <= '0;
      end else begin
         pos_ff  <= pos_in;
         col_ff  <= col_in;
         k_ff    <= k_in;
         ocol_ff <= ocol_in;
      end
   end

endmodule

`default_nettype wire

@@ design/edge3_line.sv @@
// ----------------------------------------------------------------------------
// edge3_line
// Two line stores in one memory word, registered read, write-through bypass.
// ----------------------------------------------------------------------------
`default_nettype none

module edge3_line #(
   parameter int MAX_WIDTH = 512
) (
   input  logic                           clock,
   input  logic                           rd_en,
   input  logic [edge3_pkg::DIM_W-1:0]    rd_addr,
   input  logic                           wr_en,
   input  logic [edge3_pkg::DIM_W-1:0]    wr_addr,
   input  edge3_pkg::line_word_type       wr_data,
   output edge3_pkg::line_word_type       rd_data
);

   localparam int AW = $clog2(MAX_WIDTH);
   localparam int CW = (AW > edge3_pkg::DIM_W) ? AW : edge3_pkg::DIM_W;

   logic [edge3_pkg::LINE_W-1:0] mem [MAX_WIDTH];
   logic [edge3_pkg::LINE_W-1:0] rd_data_ff;
   logic [CW-1:0]                rd_ext, wr_ext;
   logic [AW-1:0]                rd_idx, wr_idx;

   assign rd_ext  = CW'(rd_addr);
   assign wr_ext  = CW'(wr_addr);
   assign rd_idx  = rd_ext[AW-1:0];
   assign wr_idx  = wr_ext[AW-1:0];
   assign rd_data = rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_idx] <= wr_data;
      end
   end

   // A one-pixel-wide image reads the column that is being written.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         if (wr_en && (wr_addr == rd_addr)) begin
            rd_data_ff <= wr_data;
         end else begin
            rd_data_ff <= mem[rd_idx];
         end
      end
   end

endmodule

`default_nettype wire

@@ design/edge3_win.sv @@
// ----------------------------------------------------------------------------
// edge3_win
// Work stage: shift the window, form the kernel sum, hold the result.
// ----------------------------------------------------------------------------
`default_nettype none

module edge3_win (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  go,
   input  edge3_pkg::item_type                   item,
   input  edge3_pkg::line_word_type              rd_data,
   output logic                                  s1_ready,
   output logic                                  wr_en,
   output logic [edge3_pkg::DIM_W-1:0]           wr_addr,
   output edge3_pkg::line_word_type              wr_data,
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   output logic [edge3_pkg::RSP_DATA_W-1:0]      rsp_tdata,
   output logic                                  rsp_tlast
);

   logic                            s1_valid_ff, s1_valid_in;
   edge3_pkg::item_type             s1_ff;
   edge3_pkg::col_type              c1_ff, c2_ff, new_col;
   logic                            out_free, fire;
   logic [edge3_pkg::CSUM_W-1:0]    cs_left, cs_right;
   logic [edge3_pkg::SUM_W-1:0]     sum;
   logic                            rsp_valid_ff, rsp_valid_in, rsp_last_ff;
   logic [edge3_pkg::SUM_W-1:0]     rsp_edge_ff;

   always_comb begin
      out_free    = ~rsp_valid_ff | rsp_tready;
      fire        = s1_valid_ff & out_free;
      s1_ready    = ~s1_valid_ff | out_free;
      s1_valid_in = go ? 1'b1 : (fire ? 1'b0 : s1_valid_ff);

      new_col.top = rd_data.upper;
      new_col.mid = rd_data.lower;
      new_col.bot = s1_ff.px;

      cs_left  = s1_ff.left_ok ? edge3_pkg::col_sum(c1_ff, s1_ff.top_ok, s1_ff.bot_ok) : '0;
      cs_right = s1_ff.right_ok ? edge3_pkg::col_sum(new_col, s1_ff.top_ok, s1_ff.bot_ok)
                                : '0;
      sum      = {1'b0, cs_left} - {1'b0, cs_right};

      rsp_valid_in = out_free ? (fire & s1_ff.has_result) : rsp_valid_ff;

      wr_en         = fire;
      wr_addr       = s1_ff.col;
      wr_data.upper = rd_data.lower;
      wr_data.lower = s1_ff.px;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (go) begin
         s1_ff <= item;
      end
      if (fire) begin
         c1_ff       <= c2_ff;
         c2_ff       <= new_col;
         rsp_edge_ff <= sum;
         rsp_last_ff <= s1_ff.last;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = edge3_pkg::RSP_DATA_W'(rsp_edge_ff);
   assign rsp_tlast  = rsp_last_ff;

endmodule

`default_nettype wire

@@ design/edge_conv3x3_stream_top.sv @@
// ----------------------------------------------------------------------------
// edge_conv3x3_stream_top
// Streaming 3x3 vertical-edge filter with zero padding, one pixel per clock.
// ----------------------------------------------------------------------------
// Feed grayscale pixels in raster order on the req_ channel (tdata = pixel,
// tuser = flush). Each result on rsp_ is the kernel sum (columns left minus
// right, three rows) for the next output position, tlast on the frame's
// final result. Result k leaves after the pixel at raster index k+W+1; once
// all W*H pixels are in, send W+1 more transfers (flush set) to drain.
// A flush transfer inside the frame is taken and dropped. Set image_width and
// image_height on the csr_ channel while idle; size writes restart the frame.
// Timing: one transfer per clock in and out unless stalled. The line-store
// read and the input register load on the transfer; the window sum then moves
// into the result register once that register is empty or being taken.
// Reset: synchronous; size returns to 512 x 512 (width clamped to MAX_WIDTH)
// and the position counters clear. Line stores need no clearing pass.
// Stall: while rsp_tready is low the result holds; one more pixel is taken
// into the work stage, then req_tready drops until the result is taken.
// ----------------------------------------------------------------------------
`default_nettype none

`include "edge_conv3x3_stream_top_macros.svh"

module edge_conv3x3_stream_top #(
   parameter int MAX_WIDTH = 512
) (
   input  logic        clock,
   input  logic        reset,
   // input pixel stream
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] pixel
   input  logic        req_tuser,   // [0] flush
   // result stream
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // [10:0] edge_value (signed), [15:11] zero
   output logic        rsp_tlast,   // last_of_frame
   // register writes
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [3:0]  csr_index,
   input  logic [9:0]  csr_wdata
);

   edge3_pkg::cfg_type       cfg;
   edge3_pkg::item_type      item;
   edge3_pkg::line_word_type rd_data, wr_data;
   logic                     restart, accept, go, wr_en;
   logic [edge3_pkg::DIM_W-1:0] wr_addr;

   // Transfer on the input side.
   assign accept = req_tvalid & req_tready;

   edge3_cfg #(
      .MAX_WIDTH (MAX_WIDTH)
   ) u_cfg (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .restart   (restart),
      .cfg       (cfg)
   );

   // Counters decide per transfer: drop, pixel or drain, and result tags.
   edge3_ctrl u_ctrl (
      .clock   (clock),
      .reset   (reset),
      .accept  (accept),
      .restart (restart),
      .cfg     (cfg),
      .pixel   (req_tdata),
      .flush   (req_tuser),
      .go      (go),
      .item    (item)
   );

   // Read both rows above at the entering column; written back on advance.
   edge3_line #(
      .MAX_WIDTH (MAX_WIDTH)
   ) u_line (
      .clock   (clock),
      .rd_en   (go),
      .rd_addr (item.col),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_data (rd_data)
   );

   edge3_win u_win (
      .clock      (clock),
      .reset      (reset),
      .go         (go),
      .item       (item),
      .rd_data    (rd_data),
      .s1_ready   (req_tready),
      .wr_en      (wr_en),
      .wr_addr    (wr_addr),
      .wr_data    (wr_data),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   // A shown result never leaves the kernel's range.
   `EDGE3_ASSERT_IMP(a_edge_range, clock, reset, rsp_tvalid,
      ($signed(rsp_tdata[10:0]) <= edge3_pkg::EDGE_MAX)
         && ($signed(rsp_tdata[10:0]) >= -edge3_pkg::EDGE_MAX),
      "edge value out of range")
   // Wider than one pixel, no column drops both side columns.
   `EDGE3_ASSERT_IMP(a_side_mask, clock, reset,
      go && item.has_result && (cfg.w != 10'd1),
      item.left_ok || item.right_ok, "both side columns masked")
   // After the final result the frame restarts, so no result follows at once.
   `EDGE3_ASSERT_NXT(a_frame_restart, clock, reset,
      go && item.has_result && item.last,
      !(go && item.has_result), "frame did not restart")

endmodule

`default_nettype wire
